### rtl/core/mfr_pkg.sv
// Shared types and constants for the meter frame receiver.
// No dependencies; imported by every module of the block.
package mfr_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned POS_W      = 5;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned MEAS_W     = 128;
	localparam int unsigned READ_W     = 64;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_MEAS = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_THIRD  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE      = 8'd3;

	localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'd171;
	localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'd205;
	localparam logic [BYTE_W-1:0] RST_HEADER_THIRD  = 8'd239;
	localparam logic [BYTE_W-1:0] RST_ACK_CODE      = 8'd6;

	localparam logic FRAME_MEAS = 1'b0;
	localparam logic FRAME_READ = 1'b1;

	typedef struct packed {
		logic [BYTE_W-1:0] header_first;
		logic [BYTE_W-1:0] header_second;
		logic [BYTE_W-1:0] header_third;
		logic [BYTE_W-1:0] ack_code;
	} mfr_cfg_t;

	typedef struct packed {
		logic        frame_kind;
		logic        checksum_ok;
		logic [31:0] rms_current;
		logic [15:0] rms_voltage;
		logic [31:0] real_power;
		logic [31:0] var_power;
		logic [15:0] mains_freq;
		logic [63:0] read_data;
	} mfr_result_t;

endpackage

### rtl/core/mfr_cfg_regs.sv
// Configuration registers: header bytes and acknowledge code.
// Depends on mfr_pkg.
module mfr_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfr_pkg::BYTE_W-1:0]     cfg_wdata,
	output mfr_pkg::mfr_cfg_t              cfg
);
	import mfr_pkg::*;

	mfr_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= RST_HEADER_FIRST;
			cfg_q.header_second <= RST_HEADER_SECOND;
			cfg_q.header_third  <= RST_HEADER_THIRD;
			cfg_q.ack_code      <= RST_ACK_CODE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_FIRST:  cfg_q.header_first  <= cfg_wdata;
				REG_HEADER_SECOND: cfg_q.header_second <= cfg_wdata;
				REG_HEADER_THIRD:  cfg_q.header_third  <= cfg_wdata;
				REG_ACK_CODE:      cfg_q.ack_code      <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/core/mfr_parser.sv
// Input register and frame parser: position, mode, checksum and field capture.
// Depends on mfr_pkg; fed by the top level, drives the output buffer.
module mfr_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mfr_pkg::mfr_cfg_t           cfg,
	input  logic                        load,
	input  logic                        hold,
	input  logic                        in_valid,
	input  logic                        func,
	input  logic [mfr_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        res_push,
	output mfr_pkg::mfr_result_t        res
);
	import mfr_pkg::*;

	localparam logic [POS_W-1:0] POS_START     = 5'd0;
	localparam logic [POS_W-1:0] POS_HDR2      = 5'd1;
	localparam logic [POS_W-1:0] POS_HDR3      = 5'd2;
	localparam logic [POS_W-1:0] POS_MEAS_DATA = 5'd3;
	localparam logic [POS_W-1:0] POS_MEAS_LAST = 5'd18;
	localparam logic [POS_W-1:0] POS_MEAS_SUM  = 5'd19;
	localparam logic [POS_W-1:0] POS_COUNT     = 5'd1;
	localparam logic [POS_W-1:0] POS_READ_DATA = 5'd2;
	localparam logic [POS_W-1:0] POS_READ_LAST = 5'd9;
	localparam logic [POS_W-1:0] POS_READ_SUM  = 5'd10;

	logic              valid_s1;
	logic              func_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic [POS_W-1:0]  pos_q, pos_n;
	logic [1:0]        mode_q, mode_n;
	logic [BYTE_W-1:0] sum_q, sum_n;
	logic              armed_q, armed_n;
	logic [MEAS_W-1:0] meas_q, meas_n;
	logic [READ_W-1:0] read_q, read_n;

	logic              work;
	logic [POS_W-1:0]  meas_off, read_off;
	logic [3:0]        meas_lane;
	logic [2:0]        read_lane;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			func_s1 <= func;
			byte_s1 <= rx_byte;
		end
	end

	assign work      = valid_s1 && !hold;
	assign meas_off  = pos_q - POS_MEAS_DATA;
	assign read_off  = pos_q - POS_READ_DATA;
	assign meas_lane = meas_off[3:0];
	assign read_lane = read_off[2:0];

	always_comb begin
		pos_n    = pos_q;
		mode_n   = mode_q;
		sum_n    = sum_q;
		armed_n  = armed_q;
		meas_n   = meas_q;
		read_n   = read_q;
		res_push = 1'b0;

		res.frame_kind  = FRAME_MEAS;
		res.checksum_ok = (byte_s1 == sum_q);
		res.rms_current = meas_q[31:0];
		res.rms_voltage = meas_q[47:32];
		res.real_power  = meas_q[79:48];
		res.var_power   = meas_q[111:80];
		res.mains_freq  = meas_q[127:112];
		res.read_data   = '0;

		if (work) begin
			if (func_s1) begin
				armed_n = 1'b1;
			end else if ((mode_q != MODE_MEAS && mode_q != MODE_READ)
					|| pos_q == POS_START) begin
				sum_n = '0;
				pos_n = POS_START;
				if (byte_s1 == cfg.header_first) begin
					mode_n = MODE_MEAS;
					sum_n  = byte_s1;
					pos_n  = POS_HDR2;
				end else if (byte_s1 == cfg.ack_code && armed_q) begin
					armed_n = 1'b0;
					mode_n  = MODE_READ;
					sum_n   = byte_s1;
					pos_n   = POS_COUNT;
				end else begin
					mode_n = MODE_IDLE;
				end
			end else if (mode_q == MODE_MEAS) begin
				if (pos_q == POS_HDR2 || pos_q == POS_HDR3) begin
					if ((pos_q == POS_HDR2 && byte_s1 == cfg.header_second)
							|| (pos_q == POS_HDR3 && byte_s1 == cfg.header_third)) begin
						sum_n = sum_q + byte_s1;
						pos_n = pos_q + 5'd1;
					end else begin
						mode_n = MODE_IDLE;
						pos_n  = POS_START;
					end
				end else if (pos_q <= POS_MEAS_LAST) begin
					meas_n[meas_lane*8 +: 8] = byte_s1;
					sum_n = sum_q + byte_s1;
					pos_n = pos_q + 5'd1;
				end else begin
					res_push = (pos_q == POS_MEAS_SUM);
					mode_n   = MODE_IDLE;
					pos_n    = POS_START;
				end
			end else begin
				res.frame_kind  = FRAME_READ;
				res.rms_current = '0;
				res.rms_voltage = '0;
				res.real_power  = '0;
				res.var_power   = '0;
				res.mains_freq  = '0;
				res.read_data   = read_q;
				if (pos_q == POS_COUNT) begin
					sum_n = sum_q + byte_s1;
					pos_n = pos_q + 5'd1;
				end else if (pos_q <= POS_READ_LAST) begin
					read_n[read_lane*8 +: 8] = byte_s1;
					sum_n = sum_q + byte_s1;
					pos_n = pos_q + 5'd1;
				end else begin
					res_push = (pos_q == POS_READ_SUM);
					mode_n   = MODE_IDLE;
					pos_n    = POS_START;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mode_q  <= MODE_IDLE;
			sum_q   <= '0;
			armed_q <= 1'b0;
			meas_q  <= '0;
			read_q  <= '0;
		end else begin
			pos_q   <= pos_n;
			mode_q  <= mode_n;
			sum_q   <= sum_n;
			armed_q <= armed_n;
			meas_q  <= meas_n;
			read_q  <= read_n;
		end
	end

endmodule

### rtl/core/mfr_out_buf.sv
// Result register with one skid entry between the parser and the output channel.
// Depends on mfr_pkg.
module mfr_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mfr_pkg::mfr_result_t  res,
	input  logic                  out_stall,
	output logic                  out_valid,
	output mfr_pkg::mfr_result_t  out_res,
	output logic                  full
);
	import mfr_pkg::*;

	mfr_result_t out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        drain;

	assign drain = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (drain) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign full      = skid_valid_q;

endmodule

### rtl/core/meter_frame_receiver_top.sv
// Meter frame receiver: one received byte per transfer, one result per frame end.
// A checksum byte passes the parser input register, then the result register, before out_valid rises.
// Throughput: one byte per cycle while in_stall is low.
// in_stall rises only while both the result register and its skid entry are full.
// Reset (arst_n low, asynchronous) restores default headers and clears the valid flags and parser frame state.
// Depends on mfr_pkg, mfr_cfg_regs, mfr_parser and mfr_out_buf.
module meter_frame_receiver_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mfr_pkg::BYTE_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [mfr_pkg::BYTE_W-1:0]     rx_byte,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           frame_kind,
	output logic                           checksum_ok,
	output logic [31:0]                    rms_current,
	output logic [15:0]                    rms_voltage,
	output logic [31:0]                    real_power,
	output logic [31:0]                    var_power,
	output logic [15:0]                    mains_freq,
	output logic [63:0]                    read_data
);
	import mfr_pkg::*;

	mfr_cfg_t    cfg;
	mfr_result_t res, out_res;
	logic        res_push;
	logic        full;

	assign in_stall = full;

	mfr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.load     (!full),
		.hold     (full),
		.in_valid (in_valid),
		.func     (func),
		.rx_byte  (rx_byte),
		.res_push (res_push),
		.res      (res)
	);

	mfr_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.full      (full)
	);

	assign frame_kind  = out_res.frame_kind;
	assign checksum_ok = out_res.checksum_ok;
	assign rms_current = out_res.rms_current;
	assign rms_voltage = out_res.rms_voltage;
	assign real_power  = out_res.real_power;
	assign var_power   = out_res.var_power;
	assign mains_freq  = out_res.mains_freq;
	assign read_data   = out_res.read_data;

endmodule

### rtl/core/mfr_checker.sv
// Port-level checks for the meter frame receiver, bound to the top level.
// Depends on mfr_pkg and meter_frame_receiver_top.
module mfr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           frame_kind,
	input logic [31:0]                    rms_current,
	input logic [15:0]                    rms_voltage,
	input logic [31:0]                    real_power,
	input logic [31:0]                    var_power,
	input logic [15:0]                    mains_freq,
	input logic [63:0]                    read_data
);
	import mfr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result waiting");

	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_kind == FRAME_READ |-> rms_current == 32'd0
			&& rms_voltage == 16'd0 && real_power == 32'd0
			&& var_power == 32'd0 && mains_freq == 16'd0)
		else $error("measurement fields set in read response");

	a_meas_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_kind == FRAME_MEAS |-> read_data == 64'd0)
		else $error("read data set in measurement frame");

endmodule

bind meter_frame_receiver_top mfr_checker u_mfr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.frame_kind  (frame_kind),
	.rms_current (rms_current),
	.rms_voltage (rms_voltage),
	.real_power  (real_power),
	.var_power   (var_power),
	.mains_freq  (mains_freq),
	.read_data   (read_data)
);

### verif/tb_meter_frame_receiver_top.sv
// Testbench for meter_frame_receiver_top: measurement and read response frames,
// header rejects, arming and checksum flags under random gaps, stalls and header settings.
// Depends on mfr_pkg and the meter_frame_receiver_top RTL only.
module tb_meter_frame_receiver_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mfr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 400;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_style_t;
	typedef enum int {TRAFFIC_MEAS, TRAFFIC_READ, TRAFFIC_BAD_HEADER, TRAFFIC_NOISE} traffic_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0]    cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = 1'b0;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 frame_kind;
	logic                 checksum_ok;
	logic [31:0]          rms_current;
	logic [15:0]          rms_voltage;
	logic [31:0]          real_power;
	logic [31:0]          var_power;
	logic [15:0]          mains_freq;
	logic [63:0]          read_data;

	meter_frame_receiver_top dut (.*);

	always #10 clk = ~clk;

	// header settings and parser state as the block should hold them
	mfr_cfg_t          hdr_cfg = '{RST_HEADER_FIRST, RST_HEADER_SECOND, RST_HEADER_THIRD,
		RST_ACK_CODE};
	logic [POS_W-1:0]  parse_pos = '0;
	logic [1:0]        parse_mode = MODE_IDLE;
	logic [7:0]        byte_sum = '0;
	logic              read_armed = 1'b0;
	logic [MEAS_W-1:0] meas_bytes = '0;
	logic [READ_W-1:0] read_bytes = '0;

	mfr_result_t frames_due[$];
	mfr_result_t got_frame, want_frame;

	int  mismatches = 0;
	int  bytes_sent = 0;
	int  burst_left = 0;
	bit  gaps_enabled = 1'b1;
	int  hold_request = 0;
	int  hold_left = 0;
	int  style_left = 0;
	int  cycle_count = 0;
	stall_style_t stall_style = STALL_NONE;

	function automatic void take_byte(input logic [7:0] b);
		byte_sum  = byte_sum + b;
		parse_pos = parse_pos + 1'b1;
	endfunction

	function automatic void go_idle();
		parse_pos  = '0;
		parse_mode = MODE_IDLE;
	endfunction

	function automatic void track_byte(input logic f, input logic [7:0] b);
		mfr_result_t res;
		res = '0;
		if (f) begin
			read_armed = 1'b1;
			return;
		end
		if ((parse_mode != MODE_MEAS && parse_mode != MODE_READ) || parse_pos == 0) begin
			byte_sum  = '0;
			parse_pos = '0;
			if (b == hdr_cfg.header_first) begin
				parse_mode = MODE_MEAS;
				take_byte(b);
			end else if (b == hdr_cfg.ack_code && read_armed) begin
				read_armed = 1'b0;
				parse_mode = MODE_READ;
				take_byte(b);
			end else begin
				go_idle();
			end
			return;
		end
		if (parse_mode == MODE_MEAS) begin
			if (parse_pos == 1) begin
				if (b == hdr_cfg.header_second) take_byte(b); else go_idle();
			end else if (parse_pos == 2) begin
				if (b == hdr_cfg.header_third) take_byte(b); else go_idle();
			end else if (parse_pos <= 18) begin
				meas_bytes[8*(parse_pos-3) +: 8] = b;
				take_byte(b);
			end else if (parse_pos == 19) begin
				res.frame_kind  = FRAME_MEAS;
				res.checksum_ok = (b == byte_sum);
				res.rms_current = meas_bytes[31:0];
				res.rms_voltage = meas_bytes[47:32];
				res.real_power  = meas_bytes[79:48];
				res.var_power   = meas_bytes[111:80];
				res.mains_freq  = meas_bytes[127:112];
				frames_due.push_back(res);
				go_idle();
			end else begin
				go_idle();
			end
		end else begin
			if (parse_pos == 1) begin
				take_byte(b);
			end else if (parse_pos <= 9) begin
				read_bytes[8*(parse_pos-2) +: 8] = b;
				take_byte(b);
			end else if (parse_pos == 10) begin
				res.frame_kind  = FRAME_READ;
				res.checksum_ok = (b == byte_sum);
				res.read_data   = read_bytes;
				frames_due.push_back(res);
				go_idle();
			end else begin
				go_idle();
			end
		end
	endfunction

	task automatic send_byte(input logic f, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_enabled ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		func     <= f;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		track_byte(f, b);
		bytes_sent++;
	endtask

	// drop valid and wait until every frame due has been seen
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HEADER_FIRST:  hdr_cfg.header_first  = val;
			REG_HEADER_SECOND: hdr_cfg.header_second = val;
			REG_HEADER_THIRD:  hdr_cfg.header_third  = val;
			REG_ACK_CODE:      hdr_cfg.ack_code      = val;
			default: ;
		endcase
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [MEAS_W-1:0] rand_payload();
		logic [MEAS_W-1:0] p;
		for (int i = 0; i < MEAS_W / 8; i++) p[8*i +: 8] = rand_byte();
		return p;
	endfunction

	// arm_at >= 0 slips an arm transfer in before that frame byte
	task automatic send_meas(input logic [MEAS_W-1:0] payload, input bit bad_sum, input int arm_at);
		logic [7:0] s;
		logic [7:0] b;
		s = '0;
		for (int i = 0; i < 19; i++) begin
			if (i == arm_at) send_byte(1'b1, rand_byte());
			case (i)
				0:       b = hdr_cfg.header_first;
				1:       b = hdr_cfg.header_second;
				2:       b = hdr_cfg.header_third;
				default: b = payload[8*(i-3) +: 8];
			endcase
			send_byte(1'b0, b);
			s = s + b;
		end
		send_byte(1'b0, bad_sum ? 8'(s + $urandom_range(1, 255)) : s);
	endtask

	task automatic send_read(input logic [READ_W-1:0] data, input logic [7:0] count,
		input bit bad_sum);
		logic [7:0] s;
		send_byte(1'b1, rand_byte());
		send_byte(1'b0, hdr_cfg.ack_code);
		send_byte(1'b0, count);
		s = hdr_cfg.ack_code + count;
		for (int i = 0; i < 8; i++) begin
			send_byte(1'b0, data[8*i +: 8]);
			s = s + data[8*i +: 8];
		end
		send_byte(1'b0, bad_sum ? 8'(s + $urandom_range(1, 255)) : s);
	endtask

	task automatic send_bad_header(input bit at_third);
		send_byte(1'b0, hdr_cfg.header_first);
		if (at_third) begin
			send_byte(1'b0, hdr_cfg.header_second);
			send_byte(1'b0, hdr_cfg.header_third ^ 8'($urandom_range(1, 255)));
		end else begin
			send_byte(1'b0, hdr_cfg.header_second ^ 8'($urandom_range(1, 255)));
		end
	endtask

	task automatic run_traffic(input int n);
		int       first;
		traffic_t kind;
		logic [MEAS_W-1:0] wide_data;
		first = bytes_sent;
		while (bytes_sent - first < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: kind = TRAFFIC_MEAS;
				6, 7:             kind = TRAFFIC_READ;
				8:                kind = TRAFFIC_BAD_HEADER;
				default:          kind = TRAFFIC_NOISE;
			endcase
			case (kind)
				TRAFFIC_MEAS:
					send_meas(rand_payload(), $urandom_range(0, 4) == 0,
						($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 18)) : -1);
				TRAFFIC_READ: begin
					wide_data = rand_payload();
					send_read(wide_data[READ_W-1:0], rand_byte(), $urandom_range(0, 4) == 0);
				end
				TRAFFIC_BAD_HEADER:
					send_bad_header(1'($urandom_range(0, 1)));
				default:
					repeat ($urandom_range(1, 4))
						send_byte($urandom_range(0, 3) == 0, rand_byte());
			endcase
		end
	endtask

	task automatic apply_headers(input mfr_cfg_t c);
		settle();
		write_reg(REG_HEADER_FIRST, c.header_first);
		write_reg(REG_HEADER_SECOND, c.header_second);
		write_reg(REG_HEADER_THIRD, c.header_third);
		write_reg(REG_ACK_CODE, c.ack_code);
	endtask

	task automatic test_directed_frames();
		send_byte(1'b0, hdr_cfg.ack_code);
		send_read({READ_W{1'b1}}, 8'hFF, 1'b1);
		send_bad_header(1'b0);
		send_bad_header(1'b1);
		send_meas({MEAS_W{1'b1}}, 1'b0, 10);
		send_meas('0, 1'b1, -1);
	endtask

	task automatic test_receiver_hold();
		settle();
		hold_request = HOLD_CYCLES;
		gaps_enabled = 1'b0;
		repeat (8) send_meas(rand_payload(), 1'b0, -1);
		gaps_enabled = 1'b1;
		settle();
	endtask

	task automatic test_header_sweep();
		mfr_cfg_t c;
		run_traffic(200);
		apply_headers('{8'h00, 8'h00, 8'h00, 8'h00});
		run_traffic(200);
		apply_headers('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
		run_traffic(200);
		repeat (2) begin
			c = '{rand_byte(), rand_byte(), rand_byte(), rand_byte()};
			apply_headers(c);
			run_traffic(200);
		end
	endtask

	// receiver: a long hold when asked, otherwise a stall style that changes now and then
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (style_left == 0) begin
				stall_style = stall_style_t'($urandom_range(0, 2));
				style_left  = $urandom_range(32, 256);
			end
			style_left--;
			case (stall_style)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				default:     out_stall <= ($urandom_range(0, 4) != 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_frame = '{frame_kind, checksum_ok, rms_current, rms_voltage, real_power,
				var_power, mains_freq, read_data};
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected frame: kind %0d ok %0d cur %h volt %h act %h react %h freq %h read %h",
						got_frame.frame_kind, got_frame.checksum_ok, got_frame.rms_current,
						got_frame.rms_voltage, got_frame.real_power,
						got_frame.var_power, got_frame.mains_freq,
						got_frame.read_data);
			end else begin
				want_frame = frames_due.pop_front();
				if (got_frame !== want_frame) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("frame mismatch at %0t", $realtime);
						$display("  want kind %0d ok %0d cur %h volt %h act %h react %h freq %h read %h",
							want_frame.frame_kind, want_frame.checksum_ok,
							want_frame.rms_current, want_frame.rms_voltage,
							want_frame.real_power, want_frame.var_power,
							want_frame.mains_freq, want_frame.read_data);
						$display("  got  kind %0d ok %0d cur %h volt %h act %h react %h freq %h read %h",
							got_frame.frame_kind, got_frame.checksum_ok,
							got_frame.rms_current, got_frame.rms_voltage,
							got_frame.real_power, got_frame.var_power,
							got_frame.mains_freq, got_frame.read_data);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_frames();
		test_receiver_hold();
		test_header_sweep();
		settle();
		if (mismatches == 0 && frames_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
